// ===== hdl/segmented_vector_store_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for segmented_vector_store
// Implication checks on clk, disabled while the async reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_VECTOR_STORE_ASSERT_SVH
`define SEGMENTED_VECTOR_STORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define SVS_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) \
		(ante) |-> (cons)) else $error(msg);
// Delayed implication: the consequent is checked after the antecedent.
`define SVS_ASSERT_LAT2(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) \
		(ante) |-> ##2 (cons)) else $error(msg);
`else
`define SVS_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg)
`define SVS_ASSERT_LAT2(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

// ===== hdl/svs_pkg.sv =====
// ----------------------------------------------------------------------------
// svs_pkg
// Shared constants, codes and types of the segmented vector store.
// ----------------------------------------------------------------------------
package svs_pkg;

	localparam int LEVELS = 9;
	localparam int MAXCAP = (1 << (LEVELS + 1)) - 2;
	localparam int CNT_W  = 10;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(MAXCAP);
	localparam int QDEPTH = 2;

	localparam logic [CNT_W:0] MAXCAP_X = (CNT_W + 1)'(MAXCAP);

	typedef enum logic [2:0] {
		MODE_PUSH    = 3'd0,
		MODE_POP     = 3'd1,
		MODE_READ    = 3'd2,
		MODE_WRITE   = 3'd3,
		MODE_RESERVE = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_MAX   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_WRITE = 2'd2
	} kind_t;

	// One classified transaction on its way to the storage side.
	typedef struct packed {
		kind_t               kind;
		logic [ADDR_W-1:0]   addr;
		logic [DATA_W-1:0]   data;
		status_t             status;
		logic [CNT_W-1:0]    size;
		logic [CNT_W-1:0]    cap;
	} op_t;

	// Smallest bucket boundary 2^(k+1)-2 (k >= 1) that holds n elements.
	function automatic logic [CNT_W:0] grow_cap(input logic [CNT_W:0] n);
		logic [CNT_W:0] res;
		res = MAXCAP_X;
		for (int k = LEVELS; k >= 1; k--) begin
			if (n <= (CNT_W + 1)'((1 << (k + 1)) - 2)) begin
				res = (CNT_W + 1)'((1 << (k + 1)) - 2);
			end
		end
		return res;
	endfunction

endpackage

// ===== hdl/svs_front.sv =====
// ----------------------------------------------------------------------------
// svs_front
// Classifies each transaction, keeps size and capacity, emits a storage op.
// ----------------------------------------------------------------------------
module svs_front import svs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [2:0]               mode,
	input  logic [CNT_W-1:0]         index,
	input  logic signed [DATA_W-1:0] value,
	output op_t                      op
);

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] next_cnt;
	logic [CNT_W-1:0] next_cap;
	logic [CNT_W:0]   cnt_inc;
	logic [CNT_W:0]   grow_arg;
	logic [CNT_W:0]   grow_res;
	logic [CNT_W:0]   index_x;

	assign cnt_inc  = {1'b0, cnt_q} + 1'b1;
	assign index_x  = {1'b0, index};
	// One growth unit shared by push and reserve.
	assign grow_arg = (mode_t'(mode) == MODE_RESERVE) ? index_x : cnt_inc;
	assign grow_res = grow_cap(grow_arg);

	always_comb begin
		next_cnt  = cnt_q;
		next_cap  = cap_q;
		op.kind   = KIND_NONE;
		op.addr   = '0;
		op.data   = value;
		op.status = ST_OK;
		case (mode_t'(mode))
			MODE_PUSH: begin
				if (cnt_q >= cap_q && cnt_inc > MAXCAP_X) begin
					op.status = ST_MAX;
				end else begin
					if (cnt_q >= cap_q) begin
						next_cap = grow_res[CNT_W-1:0];
					end
					op.kind  = KIND_WRITE;
					op.addr  = cnt_q[ADDR_W-1:0];
					next_cnt = cnt_inc[CNT_W-1:0];
				end
			end
			MODE_POP: begin
				if (cnt_q == '0) begin
					op.status = ST_EMPTY;
				end else begin
					next_cnt = cnt_q - 1'b1;
					op.kind  = KIND_READ;
					op.addr  = next_cnt[ADDR_W-1:0];
				end
			end
			MODE_READ, MODE_WRITE: begin
				if (index >= cnt_q || index_x >= MAXCAP_X) begin
					op.status = ST_RANGE;
				end else begin
					op.kind = (mode_t'(mode) == MODE_READ) ? KIND_READ : KIND_WRITE;
					op.addr = index[ADDR_W-1:0];
				end
			end
			MODE_RESERVE: begin
				if (index_x > MAXCAP_X) begin
					op.status = ST_MAX;
				end else if (index > cap_q) begin
					next_cap = grow_res[CNT_W-1:0];
				end
			end
			default: begin
				// unused codes: no operation
			end
		endcase
		op.size = next_cnt;
		op.cap  = next_cap;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cap_q <= '0;
		end else if (accept) begin
			cnt_q <= next_cnt;
			cap_q <= next_cap;
		end
	end

endmodule

// ===== hdl/svs_queue.sv =====
// ----------------------------------------------------------------------------
// svs_queue
// Short FIFO of classified ops between the front and the storage side.
// ----------------------------------------------------------------------------
module svs_queue import svs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  din,
	input  logic pop,
	output op_t  dout,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CQ_W  = $clog2(QDEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QDEPTH - 1);

	op_t              entries_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CQ_W-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CQ_W'(QDEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/svs_back.sv =====
// ----------------------------------------------------------------------------
// svs_back
// Element memory: carries out one queued op per cycle and registers the result.
// ----------------------------------------------------------------------------
module svs_back import svs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid,
	input  op_t                      op,
	output logic                     pop,
	output logic signed [DATA_W-1:0] read_value,
	output logic [1:0]               status,
	output logic [CNT_W-1:0]         size_now,
	output logic [CNT_W-1:0]         capacity_now,
	output logic                     done
);

	logic [DATA_W-1:0] mem [MAXCAP];
	logic [DATA_W-1:0] rdata_s1;
	kind_t             kind_s1;
	status_t           status_s1;
	logic [CNT_W-1:0]  size_s1;
	logic [CNT_W-1:0]  cap_s1;
	logic              done_q;

	// Drain the queue whenever it holds something; the receiver never stalls.
	assign pop = valid;

	always_ff @(posedge clk) begin
		if (valid) begin
			if (op.kind == KIND_WRITE) begin
				mem[op.addr] <= op.data;
			end
			rdata_s1 <= mem[op.addr];
		end
	end

	always_ff @(posedge clk) begin
		if (valid) begin
			kind_s1   <= op.kind;
			status_s1 <= op.status;
			size_s1   <= op.size;
			cap_s1    <= op.cap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid;
		end
	end

	assign read_value   = (kind_s1 == KIND_READ) ? signed'(rdata_s1) : '0;
	assign status       = status_s1;
	assign size_now     = size_s1;
	assign capacity_now = cap_s1;
	assign done         = done_q;

endmodule

// ===== hdl/segmented_vector_store.sv =====
// ----------------------------------------------------------------------------
// segmented_vector_store
// Growable vector of 32-bit words held in buckets of 2, 4, 8, ... entries.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a transaction by raising start with mode, index and value while
//   busy is low; it is taken at that rising edge. Modes: push, pop, read,
//   write, reserve. Each transaction returns exactly one result, shown for
//   one cycle with done high: read_value, status, size_now, capacity_now.
//   Path: the accepting edge writes the op into the queue; the back end
//   then registers it from the queue head into the result registers.
//   Throughput: one transaction per cycle; the front side updates size and
//   capacity in the accepting cycle, and the single element memory port
//   serves one read or write per cycle behind a two-entry queue.
//   busy rises only if that queue is full, which a draining back end avoids.
//   The receiver cannot stall; results are never held.
//   Reset: size and capacity go to zero and the queue empties at once; the
//   element memory is not cleared, since no entry below size is unwritten.
// ----------------------------------------------------------------------------
`include "segmented_vector_store_assert.svh"

module segmented_vector_store import svs_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               mode,
	input  logic [CNT_W-1:0]         index,
	input  logic signed [DATA_W-1:0] value,
	output logic                     done,
	output logic signed [DATA_W-1:0] read_value,
	output logic [1:0]               status,
	output logic [CNT_W-1:0]         size_now,
	output logic [CNT_W-1:0]         capacity_now
);

	logic accept;
	op_t  front_op;
	op_t  queue_op;
	logic q_empty;
	logic q_full;
	logic q_pop;

	// Hold off new transactions only while the queue has no room.
	assign busy   = q_full;
	assign accept = start && !busy;

	// Front: classify, update size and capacity, build the storage op.
	svs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.mode   (mode),
		.index  (index),
		.value  (value),
		.op     (front_op)
	);

	// Decouple the classifier from the memory side.
	svs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.din    (front_op),
		.pop    (q_pop),
		.dout   (queue_op),
		.empty  (q_empty),
		.full   (q_full)
	);

	// Back: access the element memory and present the result.
	svs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (!q_empty),
		.op           (queue_op),
		.pop          (q_pop),
		.read_value   (read_value),
		.status       (status),
		.size_now     (size_now),
		.capacity_now (capacity_now),
		.done         (done)
	);

	`SVS_ASSERT_LAT2(a_result_latency, clk, arst_n, accept, done, "result missing two cycles after accept")
	`SVS_ASSERT_IMPLY(a_result_has_cause, clk, arst_n, done, $past(accept, 2), "result without transaction")
	`SVS_ASSERT_IMPLY(a_size_in_cap, clk, arst_n, done, size_now <= capacity_now, "size exceeds capacity")
	`SVS_ASSERT_IMPLY(a_empty_pop, clk, arst_n, done && status == ST_EMPTY, size_now == '0 && read_value == '0, "pop-on-empty with nonzero size or data")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segmented vector store testbench
// Drives push, pop, read, write, reserve and unused-mode transactions into the
// block and checks each result against a cycle-free model of the vector that
// tracks size, bucketed capacity and stored words.
// ----------------------------------------------------------------------------

import svs_pkg::*;

// Tracks the vector as the block should see it and holds the results it owes.
class vector_tracker;

	typedef struct {
		logic [DATA_W-1:0] word;
		status_t           code;
		logic [CNT_W-1:0]  size;
		logic [CNT_W-1:0]  cap;
	} outcome_t;

	logic [DATA_W-1:0] words [MAXCAP];
	int unsigned       elem_count;
	int unsigned       alloc_cap;
	outcome_t          pending[$];
	int unsigned       mismatches;
	int unsigned       strays;
	int unsigned       taken;
	int unsigned       peak_size;
	int unsigned       status_hits [4];

	function new();
		foreach (words[i]) words[i] = '0;
		elem_count = 0;
		alloc_cap = 0;
		mismatches = 0;
		strays = 0;
		taken = 0;
		peak_size = 0;
		foreach (status_hits[i]) status_hits[i] = 0;
	endfunction

	// Add buckets from the last allocated one until need elements fit.
	function status_t extend_capacity(int unsigned need);
		int unsigned cap;
		if (need > MAXCAP)
			return ST_MAX;
		if (need <= alloc_cap)
			return ST_OK;
		cap = (alloc_cap == 0) ? 2 : alloc_cap;
		while (cap < need)
			cap = 2 * cap + 2;
		alloc_cap = cap;
		return ST_OK;
	endfunction

	function void note_transaction(logic [2:0] op, logic [CNT_W-1:0] idx,
		logic [DATA_W-1:0] val);
		outcome_t res;
		res.word = '0;
		res.code = ST_OK;
		case (op)
		MODE_PUSH: begin
			if (elem_count >= alloc_cap)
				res.code = extend_capacity(elem_count + 1);
			if (res.code == ST_OK && elem_count < MAXCAP) begin
				words[elem_count] = val;
				elem_count++;
			end else begin
				res.code = ST_MAX;
			end
		end
		MODE_POP: begin
			if (elem_count == 0) begin
				res.code = ST_EMPTY;
			end else begin
				elem_count--;
				res.word = words[elem_count];
			end
		end
		MODE_READ: begin
			if (idx >= elem_count)
				res.code = ST_RANGE;
			else
				res.word = words[idx];
		end
		MODE_WRITE: begin
			if (idx >= elem_count)
				res.code = ST_RANGE;
			else
				words[idx] = val;
		end
		MODE_RESERVE: begin
			res.code = extend_capacity(idx);
		end
		default: ;
		endcase
		res.size = CNT_W'(elem_count);
		res.cap = CNT_W'(alloc_cap);
		pending.insert(pending.size(), res);
		taken++;
		status_hits[res.code]++;
		if (elem_count > peak_size)
			peak_size = elem_count;
	endfunction

	function void check_result(logic [DATA_W-1:0] word, logic [1:0] code,
		logic [CNT_W-1:0] size, logic [CNT_W-1:0] cap);
		outcome_t want;
		if (pending.size() == 0) begin
			strays++;
			if (mismatches + strays <= 10)
				$display("unexpected result: data %h status %0d size %0d cap %0d",
					word, code, size, cap);
			return;
		end
		want = pending.pop_front();
		if (word !== want.word || code !== want.code || size !== want.size ||
			cap !== want.cap) begin
			mismatches++;
			if (mismatches + strays <= 10)
				$display({"mismatch: expected data %h status %0d size %0d cap %0d,",
					" got data %h status %0d size %0d cap %0d"},
					want.word, want.code, want.size, want.cap,
					word, code, size, cap);
		end
	endfunction

	function bit clean();
		return mismatches == 0 && strays == 0 && pending.size() == 0;
	endfunction
endclass

module testbench;
	import svs_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_ITEMS = 1800;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 1000;
	localparam logic [2:0] FIRST_UNUSED_MODE = MODE_RESERVE + 3'd1;
	localparam logic [2:0] LAST_UNUSED_MODE = '1;

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [2:0]               mode = MODE_PUSH;
	logic [CNT_W-1:0]         index = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] read_value;
	logic [1:0]               status;
	logic [CNT_W-1:0]         size_now;
	logic [CNT_W-1:0]         capacity_now;

	vector_tracker tracker = new();

	int  burst_left = 0;
	bit  filling = 1'b1;
	int  wait_cycles;

	segmented_vector_store dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.index        (index),
		.value        (value),
		.done         (done),
		.read_value   (read_value),
		.status       (status),
		.size_now     (size_now),
		.capacity_now (capacity_now)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Results show for one cycle only; take each one at the edge that ends it.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(read_value, status, size_now, capacity_now);
	end

	// Hold start low and scramble the payload, which the block must ignore.
	task automatic idle(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
			mode <= 3'($urandom);
			index <= CNT_W'($urandom);
			value <= $urandom;
		end
	endtask

	// Present one transaction and hold it until the block takes it.
	task automatic issue(input logic [2:0] op, input logic [CNT_W-1:0] idx,
		input logic [DATA_W-1:0] val);
		@(negedge clk);
		start <= 1'b1;
		mode <= op;
		index <= idx;
		value <= val;
		do @(posedge clk); while (busy);
		tracker.note_transaction(op, idx, val);
	endtask

	// Pace the sender in bursts: short gaps of varying length land on every
	// stage of the queue-and-result pipeline, and the odd long burst keeps it full.
	task automatic send(input logic [2:0] op, input logic [CNT_W-1:0] idx,
		input logic [DATA_W-1:0] val);
		if (burst_left == 0) begin
			idle(($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) :
				$urandom_range(1, 6));
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250) :
				$urandom_range(1, 24);
		end
		issue(op, idx, val);
		burst_left--;
	endtask

	// Pause the sender until every owed result has come back.
	task automatic drain_results();
		idle(1);
		while (tracker.pending.size() != 0)
			idle(1);
		burst_left = 0;
	endtask

	// Walk the size up to the maximum and back down with random content;
	// reads and writes stay mostly in range, reserves grow step by step.
	task automatic random_transaction();
		int unsigned      r;
		int unsigned      pick;
		int unsigned      sz;
		int unsigned      cp;
		int unsigned      reach;
		logic [2:0]       op;
		logic [CNT_W-1:0] idx;
		logic [DATA_W-1:0] val;
		sz = tracker.elem_count;
		cp = tracker.alloc_cap;
		r = $urandom_range(0, 99);
		pick = $urandom_range(0, 9);
		val = $urandom;
		idx = CNT_W'($urandom);
		if (filling)
			op = (r < 86) ? MODE_PUSH : (r < 89) ? MODE_POP : (r < 94) ? MODE_READ :
				(r < 97) ? MODE_WRITE : (r < 99) ? MODE_RESERVE : FIRST_UNUSED_MODE;
		else
			op = (r < 80) ? MODE_POP : (r < 84) ? MODE_PUSH : (r < 91) ? MODE_READ :
				(r < 96) ? MODE_WRITE : (r < 99) ? MODE_RESERVE : FIRST_UNUSED_MODE;
		if (op == FIRST_UNUSED_MODE)
			op = 3'($urandom_range(FIRST_UNUSED_MODE, LAST_UNUSED_MODE));
		if (op == MODE_READ || op == MODE_WRITE) begin
			if (pick < 7 && sz > 0)
				idx = CNT_W'($urandom_range(0, sz - 1));
			else if (pick < 9)
				idx = CNT_W'($urandom_range(sz, (1 << CNT_W) - 1));
		end else if (op == MODE_RESERVE && (pick < 8 || cp < MAXCAP / 2)) begin
			reach = 2 * cp + 6;
			if (reach > (1 << CNT_W) - 1)
				reach = (1 << CNT_W) - 1;
			idx = CNT_W'($urandom_range(0, reach));
		end
		if (pick == 0)
			val = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
		send(op, idx, val);
		// Turn around at the ends after lingering there a little.
		if (filling && tracker.elem_count == MAXCAP && $urandom_range(0, 9) == 0)
			filling = 1'b0;
		else if (!filling && tracker.elem_count == 0 && $urandom_range(0, 3) == 0)
			filling = 1'b1;
		else if ($urandom_range(0, 399) == 0)
			filling = !filling;
	endtask

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty vector: pop, read and write all refuse; reserve of zero is a no-op.
		send(MODE_POP, '0, '0);
		send(MODE_READ, '0, 32'h5A5A_5A5A);
		send(MODE_WRITE, '1, '1);
		send(MODE_RESERVE, '0, '0);
		// First pushes grow capacity 0 -> 2 -> 6.
		send(MODE_PUSH, '0, 32'h7FFF_FFFF);
		send(MODE_PUSH, '1, 32'h8000_0000);
		send(MODE_PUSH, '0, '1);
		send(MODE_READ, CNT_W'(0), '0);
		send(MODE_READ, CNT_W'(2), '0);
		send(MODE_READ, CNT_W'(3), '0);
		send(MODE_READ, '1, '0);
		send(MODE_WRITE, CNT_W'(1), '0);
		send(MODE_READ, CNT_W'(1), '1);
		send(MODE_WRITE, CNT_W'(3), 32'h1234_5678);
		// Reserve: grow to 14, then equal, beyond maximum, and below capacity.
		send(MODE_RESERVE, CNT_W'(7), '0);
		send(MODE_RESERVE, CNT_W'(14), '0);
		send(MODE_RESERVE, '1, '1);
		send(MODE_RESERVE, CNT_W'(3), '0);
		send(FIRST_UNUSED_MODE, '1, '1);
		send(LAST_UNUSED_MODE, '0, '0);
		// Empty it again and pop once more past the bottom.
		send(MODE_POP, '1, '1);
		send(MODE_POP, '0, '0);
		send(MODE_POP, '0, '0);
		send(MODE_POP, '0, '0);
		send(MODE_PUSH, '0, '0);
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			random_transaction();
			if (n == RANDOM_ITEMS / 2)
				drain_results();
		end
		idle(1);

		wait_cycles = 0;
		while (tracker.pending.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d transactions: %0d ok, %0d out of range, %0d over maximum,",
			tracker.taken, tracker.status_hits[ST_OK], tracker.status_hits[ST_RANGE],
			tracker.status_hits[ST_MAX]);
		$display("  %0d pops on empty; peak size %0d, final capacity %0d, %0d mismatches",
			tracker.status_hits[ST_EMPTY], tracker.peak_size, tracker.alloc_cap,
			tracker.mismatches + tracker.strays);
		if (tracker.clean())
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
